[rtl/mpfd_pkg.sv]
// Package for the Manchester pulse frame decoder.
// Holds the pulse codes, frame constants and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpfd_pkg;

  // Transaction kinds on the input channel
  localparam logic KIND_PULSE   = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Pulse duration classes with a meaning of their own
  localparam logic [7:0] CLASS_ZERO = 8'd0;
  localparam logic [7:0] CLASS_LONG = 8'd2;

  // Frame constants
  localparam logic [7:0] END_MARK    = 8'h7E;
  localparam logic [7:0] MIN_END_POS = 8'd5;
  localparam logic [7:0] LEN_POS     = 8'd4;
  localparam logic [7:0] END_OFFSET  = 8'd8;
  localparam logic [2:0] LAST_BIT    = 3'd7;

  // One decoded byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_position;
    logic       frame_end;
  } result_t;

  // Result push from the decode stage to the output buffer
  typedef struct packed {
    logic    valid;
    result_t data;
  } res_push_t;

endpackage

`default_nettype wire

[rtl/mpfd_if.sv]
// Channel interfaces of the Manchester pulse frame decoder.
// No dependencies; the payload widths match those used in mpfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Pulse / restart input channel
interface mpfd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] pulse_class;
  logic       line_level;

  modport source (output valid, output kind, output pulse_class, output line_level,
                  input ready);
  modport sink   (input valid, input kind, input pulse_class, input line_level,
                  output ready);
endinterface

// Decoded byte output channel
interface mpfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] byte_position;
  logic       frame_end;

  modport source (output valid, output data_byte, output byte_position, output frame_end,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_position, input frame_end,
                  output ready);
endinterface

`default_nettype wire

[rtl/mpfd_core.sv]
// Input register and decode stage: half-bit pairing, byte assembly, frame end.
// Depends on mpfd_pkg and mpfd_in_if.
`timescale 1ns / 1ps
`default_nettype none

module mpfd_core import mpfd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mpfd_in_if.sink    in_ch,
  input  wire logic  room,
  output res_push_t  push
);

  // Input register
  logic       s1_valid_r;
  logic       s1_kind_r;
  logic [7:0] s1_class_r;
  logic       s1_level_r;

  // Decoder state
  logic [7:0] shift_r,    shift_nxt;
  logic [2:0] bit_cnt_r,  bit_cnt_nxt;
  logic       phase_r,    phase_nxt;
  logic       zskip_r,    zskip_nxt;
  logic [7:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0] plen_r,     plen_nxt;
  logic       done_r,     done_nxt;

  logic       fire;
  logic       accept;
  logic       is_long;
  logic       is_zero;
  logic       drop;
  logic       add_bit;
  logic       byte_done;
  logic [7:0] new_shift;
  logic [7:0] plen_eff;
  logic [7:0] limit;
  logic       fin;
  logic       live_pulse;

  // Stage hand-off: the registered item is processed once the buffer has room
  assign fire        = s1_valid_r & room;
  assign in_ch.ready = ~s1_valid_r | fire;
  assign accept      = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r  <= in_ch.kind;
      s1_class_r <= in_ch.pulse_class;
      s1_level_r <= in_ch.line_level;
    end
  end

  // Pulse classification; a long pulse always yields exactly one bit
  assign is_long    = (s1_class_r == CLASS_LONG);
  assign is_zero    = (s1_class_r == CLASS_ZERO);
  assign drop       = is_zero & (~phase_r | zskip_r);
  assign add_bit    = is_long | (phase_r & ~drop);
  assign new_shift  = {shift_r[6:0], s1_level_r};
  assign byte_done  = add_bit & (bit_cnt_r == LAST_BIT);
  assign live_pulse = fire & (s1_kind_r == KIND_PULSE) & ~done_r;

  // Frame end test, with the length byte taken fresh at its position
  assign plen_eff = (byte_cnt_r == LEN_POS) ? new_shift : plen_r;
  assign limit    = plen_eff + END_OFFSET;
  assign fin      = (byte_cnt_r >= MIN_END_POS) & (byte_cnt_r >= limit) &
                    (new_shift == END_MARK);

  // Next state
  always_comb begin
    shift_nxt    = shift_r;
    bit_cnt_nxt  = bit_cnt_r;
    phase_nxt    = phase_r;
    zskip_nxt    = zskip_r;
    byte_cnt_nxt = byte_cnt_r;
    plen_nxt     = plen_r;
    done_nxt     = done_r;
    if (fire && (s1_kind_r == KIND_RESTART)) begin
      shift_nxt    = '0;
      bit_cnt_nxt  = '0;
      phase_nxt    = 1'b0;
      zskip_nxt    = 1'b0;
      byte_cnt_nxt = '0;
      plen_nxt     = '0;
      done_nxt     = 1'b0;
    end else if (live_pulse) begin
      if (drop) begin
        zskip_nxt = 1'b1;
      end
      // Long and dropped pulses leave the half-bit phase where it was
      phase_nxt = (is_long | drop) ? phase_r : ~phase_r;
      if (add_bit) begin
        shift_nxt   = new_shift;
        bit_cnt_nxt = bit_cnt_r + 3'd1;
      end
      if (byte_done) begin
        shift_nxt    = '0;
        byte_cnt_nxt = byte_cnt_r + 8'd1;
        zskip_nxt    = 1'b0;
        plen_nxt     = plen_eff;
        done_nxt     = fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= '0;
      bit_cnt_r  <= '0;
      phase_r    <= 1'b0;
      zskip_r    <= 1'b0;
      byte_cnt_r <= '0;
      plen_r     <= '0;
      done_r     <= 1'b0;
    end else begin
      shift_r    <= shift_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      phase_r    <= phase_nxt;
      zskip_r    <= zskip_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      plen_r     <= plen_nxt;
      done_r     <= done_nxt;
    end
  end

  // Result towards the output buffer
  assign push.valid              = live_pulse & byte_done;
  assign push.data.data_byte     = new_shift;
  assign push.data.byte_position = byte_cnt_r;
  assign push.data.frame_end     = fin;

endmodule

`default_nettype wire

[rtl/mpfd_out_buf.sv]
// Two-entry output register with skid slot for decoded bytes.
// Depends on mpfd_pkg and mpfd_out_if.
`timescale 1ns / 1ps
`default_nettype none

module mpfd_out_buf import mpfd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire res_push_t push,
  output logic           room,
  mpfd_out_if.source     out_ch
);

  result_t    head_r, head_nxt;
  result_t    skid_r, skid_nxt;
  logic [1:0] cnt_r,  cnt_nxt;
  logic       pop;

  assign pop  = out_ch.valid & out_ch.ready;
  assign room = (cnt_r != 2'd2) | pop;

  // Occupancy and slot moves
  always_comb begin
    head_nxt = head_r;
    skid_nxt = skid_r;
    cnt_nxt  = cnt_r;
    if (push.valid && !pop) begin
      if (cnt_r == 2'd0) begin
        head_nxt = push.data;
      end else begin
        skid_nxt = push.data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push.valid) begin
      head_nxt = skid_r;
      cnt_nxt  = cnt_r - 2'd1;
    end else if (pop && push.valid) begin
      if (cnt_r == 2'd1) begin
        head_nxt = push.data;
      end else begin
        head_nxt = skid_r;
        skid_nxt = push.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.data_byte     = head_r.data_byte;
  assign out_ch.byte_position = head_r.byte_position;
  assign out_ch.frame_end     = head_r.frame_end;

endmodule

`default_nettype wire

[rtl/manchester_pulse_frame_decoder.sv]
// Top level of the Manchester pulse frame decoder.
// Depends on mpfd_pkg, mpfd_if, mpfd_core and mpfd_out_buf.
//
// Takes one transaction per clock while the output buffer has room: a pulse
// (duration class and line level) or a restart that clears the decoder. Pulses
// are paired into half-bits, the second half of each pair gives the data bit, a
// long pulse gives one bit alone, and bits are packed MSB first into bytes. Each
// byte leaves with its position in the frame and a frame-end flag (byte 0x7E at
// a position of at least 5 and at least 8 plus byte 4, modulo 256); after frame
// end, pulses are ignored until a restart. This rate is set by the single decode
// stage between the input register and the output buffer; the two-entry output
// buffer keeps input accepted while one byte waits.
`timescale 1ns / 1ps
`default_nettype none

module manchester_pulse_frame_decoder import mpfd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mpfd_in_if.sink    in_ch,
  mpfd_out_if.source out_ch
);

  res_push_t push;
  logic      room;

  mpfd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  mpfd_out_buf u_out_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

[rtl/mpfd_checker.sv]
// Port-level checks for the Manchester pulse frame decoder, bound to the top.
// Depends on mpfd_pkg and on the top level's port names.
`timescale 1ns / 1ps
`default_nettype none

module mpfd_checker import mpfd_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_kind,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_data_byte,
  input wire logic [7:0] out_byte_position,
  input wire logic       out_frame_end
);

  // A waiting byte stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction withdrawn while stalled");

  // Input stalls only when the output is full and blocked
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output could drain");

  // A byte appearing on an empty output must come from an accepted pulse
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_kind == KIND_PULSE), 2))
    else $error("output byte without a matching pulse");

  // Frame end only on the marker at a legal position
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |->
      (out_data_byte == END_MARK) && (out_byte_position >= MIN_END_POS))
    else $error("frame end flagged on a non-marker byte");

endmodule

bind manchester_pulse_frame_decoder mpfd_checker u_mpfd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_kind           (in_ch.kind),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_data_byte     (out_ch.data_byte),
  .out_byte_position (out_ch.byte_position),
  .out_frame_end     (out_ch.frame_end)
);

`default_nettype wire
